/* hw/rtl/cnv_pkg.sv */
package cnv_pkg;

    // Defaults for the top-level parameters.
    localparam int WIN_SIZE_DEF  = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    // Fixed field and register widths.
    localparam int PIX_W        = 8;
    localparam int RGB_W        = 3 * PIX_W;
    localparam int COEF_W       = 8;
    localparam int KROWS        = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = KROWS * COEF_W;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int QUOT_W       = 8;
    localparam int QUEUE_DEPTH  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_ROW_0 = 3'd0,
        CFG_KERNEL_ROW_1 = 3'd1,
        CFG_KERNEL_ROW_2 = 3'd2,
        CFG_KERNEL_ROW_3 = 3'd3,
        CFG_KERNEL_ROW_4 = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } t_cfg_idx;

    // Kernel coefficients, indexed [row][column].
    typedef logic [KROWS-1:0][KROWS-1:0][COEF_W-1:0] t_kernel;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_WRITE
    } t_front_state;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_MAC,
        BACK_DIV,
        BACK_OUT
    } t_back_state;

    // Control travelling with a window between front, queue and back.
    typedef struct packed {
        logic valid;
        logic frame_last;
    } t_q_ctrl;

endpackage

/* hw/rtl/cnv_pix_if.sv */
interface cnv_pix_if;
    logic                      valid;
    logic                      ready;
    logic [cnv_pkg::PIX_W-1:0] red_in;
    logic [cnv_pkg::PIX_W-1:0] green_in;
    logic [cnv_pkg::PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

/* hw/rtl/cnv_res_if.sv */
interface cnv_res_if;
    logic                      valid;
    logic                      ready;
    logic [cnv_pkg::PIX_W-1:0] red_out;
    logic [cnv_pkg::PIX_W-1:0] green_out;
    logic [cnv_pkg::PIX_W-1:0] blue_out;
    logic                      frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

/* hw/rtl/cnv_front.sv */
module cnv_front #(
    parameter int WIN_SIZE  = cnv_pkg::WIN_SIZE_DEF,
    parameter int MAX_WIDTH = cnv_pkg::MAX_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    cnv_pix_if.sink                                   i_pix,
    input  logic [cnv_pkg::WIDTH_REG_W-1:0]           i_width,
    input  logic [cnv_pkg::HEIGHT_REG_W-1:0]          i_height,
    input  logic                                      i_q_full,
    output cnv_pkg::t_q_ctrl                          o_push,
    output logic [WIN_SIZE*WIN_SIZE-1:0][cnv_pkg::RGB_W-1:0] o_win
);
    import cnv_pkg::*;

    localparam int K     = WIN_SIZE;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W) + 1;
    localparam int RH_W  = ROW_W + 1;

    t_front_state r_state, n_state;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [RGB_W-1:0] r_pix;
    logic [K*K-1:0][RGB_W-1:0] r_win, n_win;
    logic [K-1:0][RGB_W-1:0]   col_chain;

    logic [CMP_W-1:0] eff_w;
    logic [RH_W-1:0]  eff_h;
    logic accept, do_write, end_line, end_frame, produce;

    // Width and height clamped to their legal ranges.
    always_comb begin
        if (i_width == '0) begin
            eff_w = CMP_W'(1);
        end else if (CMP_W'(i_width) > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = CMP_W'(i_width);
        end
        if (i_height == '0) begin
            eff_h = RH_W'(1);
        end else if (RH_W'(i_height) > RH_W'(MAX_HEIGHT)) begin
            eff_h = RH_W'(MAX_HEIGHT);
        end else begin
            eff_h = RH_W'(i_height);
        end
    end

    // Position of the current pixel within the frame.
    assign end_line  = (CMP_W'(r_col) + CMP_W'(1)) >= eff_w;
    assign end_frame = end_line && ((RH_W'(r_row) + RH_W'(1)) >= eff_h);
    assign produce   = ((RH_W'(r_row) + RH_W'(1)) >= RH_W'(K))
                    && ((CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(K));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FRONT_IDLE:  if (i_pix.valid) n_state = FRONT_WRITE;
            FRONT_WRITE: if (!(produce && i_q_full)) n_state = FRONT_IDLE;
            default:     n_state = FRONT_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        i_pix.ready = 1'b0;
        do_write    = 1'b0;
        unique case (r_state)
            FRONT_IDLE:  i_pix.ready = 1'b1;
            FRONT_WRITE: do_write    = !(produce && i_q_full);
            default:     do_write    = 1'b0;
        endcase
    end

    assign accept = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (do_write) begin
            if (end_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (end_line) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Pixel latched on its transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
        end
    end

    assign col_chain[0] = r_pix;

    // Cascaded line memories: memory m holds the row m+1 lines above.
    // Each is read on the transfer and written with the newer row in the write step, which may wait on a full queue.
    for (genvar m = 0; m < K - 1; m++) begin : g_line
        logic [RGB_W-1:0] mem [MAX_WIDTH];
        logic [RGB_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd <= mem[r_col];
            end
            if (do_write) begin
                mem[r_col] <= col_chain[m];
            end
        end

        assign col_chain[m+1] = r_rd;
    end

    // Window shifts one column left; the new column enters on the right.
    always_comb begin
        for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K - 1; j++) begin
                n_win[i*K+j] = r_win[i*K+j+1];
            end
            n_win[i*K+K-1] = col_chain[K-1-i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_win <= n_win;
        end
    end

    assign o_win             = n_win;
    assign o_push.valid      = do_write && produce;
    assign o_push.frame_last = end_frame;

    a_accept_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == FRONT_WRITE))
        else $error("front did not move to the write step after a transfer");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> !i_q_full)
        else $error("window pushed into a full queue");

endmodule

/* hw/rtl/cnv_queue.sv */
module cnv_queue #(
    parameter int WIN_SIZE = cnv_pkg::WIN_SIZE_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  cnv_pkg::t_q_ctrl                          i_push,
    input  logic [WIN_SIZE*WIN_SIZE-1:0][cnv_pkg::RGB_W-1:0] i_win,
    input  logic                                      i_pop,
    output cnv_pkg::t_q_ctrl                          o_head,
    output logic [WIN_SIZE*WIN_SIZE-1:0][cnv_pkg::RGB_W-1:0] o_win,
    output logic                                      o_full
);
    import cnv_pkg::*;

    localparam int K   = WIN_SIZE;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [K*K-1:0][RGB_W-1:0] r_win  [QUEUE_DEPTH];
    logic                      r_last [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CNW-1:0] r_cnt;

    // Window storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_win[r_wp]  <= i_win;
            r_last[r_wp] <= i_push.frame_last;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wp <= r_wp + PW'(1);
            if (i_pop)        r_rp <= r_rp + PW'(1);
            if (i_push.valid && !i_pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (!i_push.valid && i_pop) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

    assign o_full            = (r_cnt == CNW'(QUEUE_DEPTH));
    assign o_head.valid      = (r_cnt != '0);
    assign o_head.frame_last = r_last[r_rp];
    assign o_win             = r_win[r_rp];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");

endmodule

/* hw/rtl/cnv_back.sv */
module cnv_back #(
    parameter int WIN_SIZE = cnv_pkg::WIN_SIZE_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  cnv_pkg::t_q_ctrl                          i_head,
    input  logic [WIN_SIZE*WIN_SIZE-1:0][cnv_pkg::RGB_W-1:0] i_win,
    input  cnv_pkg::t_kernel                          i_kernel,
    output logic                                      o_pop,
    cnv_res_if.source                                 o_res
);
    import cnv_pkg::*;

    localparam int K      = WIN_SIZE;
    localparam int KW     = (K > 1) ? $clog2(K) : 1;
    localparam int TW     = (K * K > 1) ? $clog2(K * K) : 1;
    localparam int ACC_W  = 2 * PIX_W + $clog2(K * K + 1);
    localparam int NORM_W = COEF_W + $clog2(K * K + 1);
    localparam int BIT_W  = $clog2(QUOT_W);

    t_back_state r_state, n_state;
    logic [K*K-1:0][RGB_W-1:0] r_win;
    logic                      r_last;
    logic [KW-1:0]    r_i, r_j;
    logic [TW-1:0]    r_tap;
    logic [ACC_W-1:0] r_acc [3];
    logic [NORM_W-1:0] r_norm;
    logic [QUOT_W-1:0] r_quot [3];
    logic [BIT_W-1:0]  r_bit;

    logic [PIX_W-1:0] r_out [3];
    logic             r_out_last;
    logic             r_ovalid;

    logic [COEF_W-1:0] coef;
    logic [RGB_W-1:0]  tap_pix;
    logic [ACC_W-1:0]  dsr;
    logic last_tap, out_free, load_out, start;

    assign coef     = i_kernel[3'(r_i)][3'(r_j)];
    assign tap_pix  = r_win[r_tap];
    assign last_tap = (r_i == KW'(K - 1)) && (r_j == KW'(K - 1));
    assign dsr      = ACC_W'(r_norm) << r_bit;
    assign out_free = !r_ovalid || o_res.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BACK_IDLE: if (i_head.valid) n_state = BACK_MAC;
            BACK_MAC:  if (last_tap) n_state = BACK_DIV;
            BACK_DIV:  if (r_bit == '0) n_state = BACK_OUT;
            BACK_OUT:  if (out_free) n_state = BACK_IDLE;
            default:   n_state = BACK_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BACK_IDLE: start    = i_head.valid;
            BACK_OUT:  load_out = out_free;
            default:   start    = 1'b0;
        endcase
    end

    assign o_pop = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BACK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Multiply-accumulate over the taps, one tap a cycle, then restoring
    // division one quotient bit a cycle for all three channels.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_win  <= i_win;
            r_last <= i_head.frame_last;
            r_i    <= '0;
            r_j    <= '0;
            r_tap  <= '0;
            r_norm <= '0;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_state == BACK_MAC) begin
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= r_acc[c]
                          + ACC_W'(tap_pix[c*PIX_W +: PIX_W]) * ACC_W'(coef);
            end
            r_norm <= r_norm + NORM_W'(coef);
            r_tap  <= r_tap + TW'(1);
            if (r_j == KW'(K - 1)) begin
                r_j <= '0;
                r_i <= r_i + KW'(1);
            end else begin
                r_j <= r_j + KW'(1);
            end
            r_bit <= BIT_W'(QUOT_W - 1);
        end else if (r_state == BACK_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (r_acc[c] >= dsr) begin
                    r_acc[c]         <= r_acc[c] - dsr;
                    r_quot[c][r_bit] <= 1'b1;
                end else begin
                    r_quot[c][r_bit] <= 1'b0;
                end
            end
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    // Output register; a zero kernel sum gives zero results.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= (r_norm == '0) ? '0 : r_quot[c];
            end
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.red_out    = r_out[0];
    assign o_res.green_out  = r_out[1];
    assign o_res.blue_out   = r_out[2];
    assign o_res.frame_last = r_out_last;

    a_zero_norm_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && (r_norm == '0)) |=>
            (r_out[0] == '0) && (r_out[1] == '0) && (r_out[2] == '0))
        else $error("zero kernel sum did not give zero results");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BACK_MAC))
        else $error("back did not start accumulating after taking a window");

endmodule

/* hw/rtl/normalized_2d_convolution_top.sv */
// Channel   Direction  Content
// i_pix     in         red_in, green_in, blue_in of one padded pixel, raster order
// o_res     out        red_out, green_out, blue_out, frame_last
// i_cfg_*   in         write port: kernel rows 0..4, image width, image height
//
// The front reads the line memories on a pixel's transfer and takes no new pixel
// until its write step, which may wait on a full queue, writes them back and
// shifts the window. For each window the back takes it from the queue, runs one
// tap of the shared multiply-accumulate per cycle, then eight quotient bits, one per
// cycle, and loads the output register, which waits while it is full.
// A two-entry window queue lets the front run on while the back works or stalls.
// Reset is synchronous; counters, queue and handshakes clear, no memory clearing.
module normalized_2d_convolution_top #(
    parameter int WIN_SIZE  = cnv_pkg::WIN_SIZE_DEF,
    parameter int MAX_WIDTH = cnv_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cnv_pix_if.sink                          i_pix,
    cnv_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cnv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cnv_pkg::*;

    localparam int K = WIN_SIZE;

    t_kernel                  r_kernel;
    logic [WIDTH_REG_W-1:0]   r_width;
    logic [HEIGHT_REG_W-1:0]  r_height;

    t_q_ctrl                   push, head;
    logic [K*K-1:0][RGB_W-1:0] push_win, head_win;
    logic                      q_full, pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
            r_width  <= WIDTH_REG_W'(1024);
            r_height <= HEIGHT_REG_W'(4096);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KERNEL_ROW_0: r_kernel[0] <= i_cfg_data;
                CFG_KERNEL_ROW_1: r_kernel[1] <= i_cfg_data;
                CFG_KERNEL_ROW_2: r_kernel[2] <= i_cfg_data;
                CFG_KERNEL_ROW_3: r_kernel[3] <= i_cfg_data;
                CFG_KERNEL_ROW_4: r_kernel[4] <= i_cfg_data;
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    cnv_front #(.WIN_SIZE(WIN_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_width  (r_width),
        .i_height (r_height),
        .i_q_full (q_full),
        .o_push   (push),
        .o_win    (push_win)
    );

    cnv_queue #(.WIN_SIZE(WIN_SIZE)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_win   (push_win),
        .i_pop   (pop),
        .o_head  (head),
        .o_win   (head_win),
        .o_full  (q_full)
    );

    cnv_back #(.WIN_SIZE(WIN_SIZE)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_win    (head_win),
        .i_kernel (r_kernel),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule
